/* hdl/string_literal_unescape_assert.svh */
// assertion macros shared by the string literal unescape block
`ifndef STRING_LITERAL_UNESCAPE_ASSERT_SVH
`define STRING_LITERAL_UNESCAPE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SLE_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("string_literal_unescape: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SLE_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("string_literal_unescape: next-cycle check failed");

`endif

/* hdl/sle_pkg.sv */
`default_nettype none
package sle_pkg;

  localparam int MaxResults = 3;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_TEXT  = 2'd1,
    KIND_END   = 2'd2
  } in_kind_t;

  typedef enum logic [1:0] {
    OUT_BYTE  = 2'd0,
    OUT_CLOSE = 2'd1,
    OUT_ERROR = 2'd2
  } out_kind_t;

  typedef enum logic [1:0] {
    ERR_UNTERM     = 2'd0,
    ERR_INCOMPLETE = 2'd1,
    ERR_INVALID    = 2'd2
  } err_code_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_BODY   = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_VQUOTE = 3'd4
  } mode_t;

  typedef struct packed {
    out_kind_t  kind;
    logic [7:0] data;
    err_code_t  err;
    logic       cons;
  } res_t;

  // all results caused by one input transaction
  typedef struct packed {
    res_t [MaxResults-1:0] r;
    logic [1:0]            n;
  } group_t;

  function automatic res_t mk_res(out_kind_t kind, logic [7:0] data, err_code_t err,
                                  logic cons);
    res_t x;
    x.kind = kind;
    x.data = data;
    x.err  = err;
    x.cons = cons;
    return x;
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else v = 5'h10;
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/sle_decode.sv */
`default_nettype none
module sle_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [1:0]      kind,
  input  wire logic [7:0]      in_byte,
  input  wire logic [7:0]      quote_char,
  input  wire logic            verbatim,
  output sle_pkg::group_t      grp
);

  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChBack  = 8'h5C;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowN  = 8'h6E;
  localparam logic [7:0] ChLowR  = 8'h72;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLowU  = 8'h75;

  sle_pkg::mode_t mode, mode_next;
  logic [7:0]  quote_byte, quote_byte_next;
  logic        verbatim_mode, verbatim_mode_next;
  logic [15:0] acc, acc_next;
  logic [2:0]  hex_count, hex_count_next;
  logic        hex_bad, hex_bad_next;

  logic [4:0]  hv;
  logic [15:0] cp;
  logic [2:0]  cnt_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= sle_pkg::MODE_IDLE;
      quote_byte    <= '0;
      verbatim_mode <= 1'b0;
      acc           <= '0;
      hex_count     <= '0;
      hex_bad       <= 1'b0;
    end else if (take) begin
      mode          <= mode_next;
      quote_byte    <= quote_byte_next;
      verbatim_mode <= verbatim_mode_next;
      acc           <= acc_next;
      hex_count     <= hex_count_next;
      hex_bad       <= hex_bad_next;
    end
  end

  always_comb begin
    mode_next          = mode;
    quote_byte_next    = quote_byte;
    verbatim_mode_next = verbatim_mode;
    acc_next           = acc;
    hex_count_next     = hex_count;
    hex_bad_next       = hex_bad;
    grp                = '0;
    hv                 = sle_pkg::hex_value(in_byte);
    cp                 = hv[4] ? acc : {acc[11:0], hv[3:0]};
    cnt_inc            = hex_count + 3'd1;
    case (sle_pkg::in_kind_t'(kind))
      sle_pkg::KIND_START: begin
        quote_byte_next    = quote_char;
        verbatim_mode_next = verbatim;
        mode_next          = sle_pkg::MODE_BODY;
        acc_next           = '0;
        hex_count_next     = '0;
        hex_bad_next       = 1'b0;
      end
      sle_pkg::KIND_END: begin
        if (mode != sle_pkg::MODE_IDLE) begin
          grp.n = 2'd1;
          case (mode)
            sle_pkg::MODE_VQUOTE:
              grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_CLOSE, 8'h00, sle_pkg::ERR_UNTERM, 1'b0);
            sle_pkg::MODE_HEX:
              grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_ERROR, 8'h00, sle_pkg::ERR_INCOMPLETE,
                                         1'b0);
            default:
              grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_ERROR, 8'h00, sle_pkg::ERR_UNTERM, 1'b0);
          endcase
          mode_next = sle_pkg::MODE_IDLE;
        end
      end
      sle_pkg::KIND_TEXT: begin
        case (mode)
          sle_pkg::MODE_BODY: begin
            if (in_byte == quote_byte) begin
              if (verbatim_mode) begin
                mode_next = sle_pkg::MODE_VQUOTE;
              end else begin
                grp.n     = 2'd1;
                grp.r[0]  = sle_pkg::mk_res(sle_pkg::OUT_CLOSE, 8'h00, sle_pkg::ERR_UNTERM,
                                            1'b1);
                mode_next = sle_pkg::MODE_IDLE;
              end
            end else if (in_byte == ChNl) begin
              grp.n     = 2'd1;
              grp.r[0]  = sle_pkg::mk_res(sle_pkg::OUT_ERROR, 8'h00, sle_pkg::ERR_UNTERM, 1'b0);
              mode_next = sle_pkg::MODE_IDLE;
            end else if (!verbatim_mode && in_byte == ChBack) begin
              mode_next = sle_pkg::MODE_ESC;
            end else begin
              grp.n    = 2'd1;
              grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, in_byte, sle_pkg::ERR_UNTERM, 1'b1);
            end
          end
          sle_pkg::MODE_VQUOTE: begin
            grp.n = 2'd1;
            if (in_byte == quote_byte) begin
              grp.r[0]  = sle_pkg::mk_res(sle_pkg::OUT_BYTE, in_byte, sle_pkg::ERR_UNTERM, 1'b1);
              mode_next = sle_pkg::MODE_BODY;
            end else begin
              // lone quote closed the literal, this byte is not part of it
              grp.r[0]  = sle_pkg::mk_res(sle_pkg::OUT_CLOSE, 8'h00, sle_pkg::ERR_UNTERM, 1'b0);
              mode_next = sle_pkg::MODE_IDLE;
            end
          end
          sle_pkg::MODE_ESC: begin
            mode_next = sle_pkg::MODE_BODY;
            grp.n     = 2'd1;
            case (in_byte)
              ChLowN: grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, ChNl, sle_pkg::ERR_UNTERM,
                                                 1'b1);
              ChLowR: grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, ChCr, sle_pkg::ERR_UNTERM,
                                                 1'b1);
              ChLowT: grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, ChTab, sle_pkg::ERR_UNTERM,
                                                 1'b1);
              ChZero: grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, 8'h00, sle_pkg::ERR_UNTERM,
                                                 1'b1);
              ChBack, ChSq, ChDq:
                grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, in_byte, sle_pkg::ERR_UNTERM,
                                           1'b1);
              ChLowU: begin
                grp.n          = 2'd0;
                mode_next      = sle_pkg::MODE_HEX;
                acc_next       = '0;
                hex_count_next = '0;
                hex_bad_next   = 1'b0;
              end
              default: begin
                // unknown escape keeps the backslash
                grp.n    = 2'd2;
                grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, ChBack, sle_pkg::ERR_UNTERM, 1'b1);
                grp.r[1] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, in_byte, sle_pkg::ERR_UNTERM,
                                           1'b1);
              end
            endcase
          end
          sle_pkg::MODE_HEX: begin
            acc_next       = cp;
            hex_bad_next   = hex_bad | hv[4];
            hex_count_next = cnt_inc;
            if (cnt_inc >= 3'd4) begin
              acc_next       = '0;
              hex_count_next = '0;
              hex_bad_next   = 1'b0;
              if (hex_bad | hv[4]) begin
                grp.n     = 2'd1;
                grp.r[0]  = sle_pkg::mk_res(sle_pkg::OUT_ERROR, 8'h00, sle_pkg::ERR_INVALID,
                                            1'b1);
                mode_next = sle_pkg::MODE_IDLE;
              end else begin
                mode_next = sle_pkg::MODE_BODY;
                if (cp[15:7] == '0) begin
                  grp.n    = 2'd1;
                  grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, cp[7:0], sle_pkg::ERR_UNTERM,
                                             1'b1);
                end else if (cp[15:11] == '0) begin
                  grp.n    = 2'd2;
                  grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, {3'b110, cp[10:6]},
                                             sle_pkg::ERR_UNTERM, 1'b1);
                  grp.r[1] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, {2'b10, cp[5:0]},
                                             sle_pkg::ERR_UNTERM, 1'b1);
                end else begin
                  grp.n    = 2'd3;
                  grp.r[0] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, {4'b1110, cp[15:12]},
                                             sle_pkg::ERR_UNTERM, 1'b1);
                  grp.r[1] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, {2'b10, cp[11:6]},
                                             sle_pkg::ERR_UNTERM, 1'b1);
                  grp.r[2] = sle_pkg::mk_res(sle_pkg::OUT_BYTE, {2'b10, cp[5:0]},
                                             sle_pkg::ERR_UNTERM, 1'b1);
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/string_literal_unescape.sv */
`default_nettype none
// Streaming unescaper for quoted string literals. One input transaction is taken per
// cycle unless in_stall is high; its results are decoded in the same cycle into a result
// register that drains one result per cycle while out_stall is low. Items with zero or
// one result sustain one item per cycle when out_stall stays low; an item with k results
// (kept escapes give two, \uXXXX up to three UTF-8 bytes) stalls the input until the last
// is taken. The first result is valid in the cycle after its input. No clearing pass after reset.
module string_literal_unescape (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] in_byte,
  input  wire logic [7:0] quote_char,
  input  wire logic       verbatim,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic [1:0]      error_code,
  output logic            consumed,
  output logic            last
);

  sle_pkg::group_t dec_grp;
  sle_pkg::res_t [sle_pkg::MaxResults-1:0] res;
  sle_pkg::res_t cur;
  logic [1:0] n;
  logic [1:0] idx;
  logic in_take;
  logic out_take;

  sle_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .take       (in_take),
    .kind       (kind),
    .in_byte    (in_byte),
    .quote_char (quote_char),
    .verbatim   (verbatim),
    .grp        (dec_grp)
  );

  assign out_valid = (n != 2'd0);
  assign last      = (idx == n - 2'd1);
  assign out_take  = out_valid && !out_stall;
  // a new transaction may enter as the final pending result leaves
  assign in_stall  = out_valid && !(out_take && last);
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= 2'd0;
      idx <= 2'd0;
    end else if (in_take && dec_grp.n != 2'd0) begin
      n   <= dec_grp.n;
      idx <= 2'd0;
    end else if (out_take) begin
      if (last) begin
        n   <= 2'd0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && dec_grp.n != 2'd0) begin
      res <= dec_grp.r;
    end
  end

  always_comb begin
    case (idx)
      2'd0:    cur = res[0];
      2'd1:    cur = res[1];
      2'd2:    cur = res[2];
      default: cur = res[0];
    endcase
  end

  assign out_kind   = cur.kind;
  assign out_byte   = cur.data;
  assign error_code = cur.err;
  assign consumed   = cur.cons;

`include "string_literal_unescape_assert.svh"

  `SLE_ASSERT_NOW(a_hold_input, clk, rst, out_valid && !last, in_stall)
  `SLE_ASSERT_NOW(a_close_error_last, clk, rst,
                  out_valid && out_kind != sle_pkg::OUT_BYTE, last)
  `SLE_ASSERT_NEXT(a_drain_empty, clk, rst, out_take && last && !in_take, !out_valid)
  `SLE_ASSERT_NEXT(a_step_index, clk, rst, out_take && !last, out_valid && idx == $past(idx) + 2'd1)

endmodule
`default_nettype wire
